// ----- src/bbc_pkg.sv -----
// Package for the block buffer cache tag table: sizes, codes, entry and result types.
// No dependencies; every other file in src imports it.
`default_nettype none

package bbc_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 5;
    localparam int WIDE_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int CNT_W   = 8;
    localparam int TIME_W  = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2
    } status_t;

    typedef struct packed {
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block;
        logic              assigned;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] last_use;
        logic              valid;
    } entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              hit;
        logic              needs_read;
        status_t           status;
        logic [CNT_W-1:0]  count_after;
    } rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == COUNT_MAX) ? c : c + CNT_W'(1);
        return r;
    endfunction

    // low slot bits of an entry index
    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(i);
        return w[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/bbc_req_if.sv -----
// Request channel of the block buffer cache: valid/ready plus one command item.
// Depends on bbc_pkg for field widths and the command type.
`default_nettype none

interface bbc_req_if import bbc_pkg::*;;
    logic              valid;
    logic              ready;
    cmd_t              command;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;

    modport source (output valid, command, device, block_number, slot, now, input ready);
    modport sink   (input valid, command, device, block_number, slot, now, output ready);
endinterface

`default_nettype wire

// ----- src/bbc_rsp_if.sv -----
// Result channel of the block buffer cache: valid/ready plus one result item.
// Depends on bbc_pkg for field widths and the status type.
`default_nettype none

interface bbc_rsp_if import bbc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_out;
    logic              hit;
    logic              needs_read;
    status_t           status;
    logic [CNT_W-1:0]  count_after;

    modport source (output valid, slot_out, hit, needs_read, status, count_after, input ready);
    modport sink   (input valid, slot_out, hit, needs_read, status, count_after, output ready);
endinterface

`default_nettype wire

// ----- src/block_buffer_cache_lru_core.sv -----
// Top level of the block buffer cache tag table with reference counts and LRU reuse.
// Depends on bbc_pkg, bbc_req_if and bbc_rsp_if.
//
// Usage:
//   req carries one command item: get (device, block_number), or release, pin or
//   unpin of a slot (release stamps now on the last reference). rsp returns
//   exactly one result item per command, in order.
//   All entry state sits in one synchronous table with a registered read port and
//   a separate write port, one entry per word, written back after modify.
//   A get walks every entry through the read port, one per cycle, to find a tag
//   match and the oldest unreferenced entry, then writes back the hit or claimed
//   entry. Release, pin and unpin read their slot, write it back unless the count
//   would underflow, then load the result; a slot outside the table loads the
//   result directly. One command is in work at a time; req.ready is high only
//   while no command is in work.
//   The result register decouples rsp: the next command is accepted while a
//   result still waits, and a finished command holds in its last step until
//   the result register is free, so a stalled receiver loses nothing.
//   Reset clears the control state and a written flag per entry; an entry never
//   written reads as unassigned with zero count, time and valid, so no clearing
//   pass is needed and the block takes items right after reset.
`default_nettype none

module block_buffer_cache_lru_core import bbc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bbc_req_if.sink   req,
    bbc_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } state_t;

    // Control and payload registers
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    rd_addr_reg, rd_addr_next;
    cmd_t                cmd_reg, cmd_next;
    logic [DEV_W-1:0]    dev_reg, dev_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    entry_t              hit_ent_reg, hit_ent_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [TIME_W-1:0]   free_lu_reg, free_lu_next;
    rsp_t                res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;
    logic [ENTRIES-1:0]  written_reg, written_next;

    // Entry table and its read side
    entry_t              mem [ENTRIES];
    entry_t              rd_data_reg;
    logic                rd_written_reg;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;

    entry_t              eff;
    logic                match_now;
    logic                free_now;
    logic [WIDE_W-1:0]   slot_wide;
    logic                slot_in_range;
    logic                accept;
    logic                out_load;
    logic [CNT_W-1:0]    cnt_new;
    logic [TIME_W-1:0]   lu_new;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    assign slot_wide     = WIDE_W'(req.slot);
    assign slot_in_range = (slot_wide < WIDE_W'(ENTRIES));

    // An entry never written reads as its reset value; tag bits are don't-care there
    always_comb
    begin
        eff = rd_data_reg;
        if (!rd_written_reg)
        begin
            eff.assigned = 1'b0;
            eff.count    = '0;
            eff.last_use = '0;
            eff.valid    = 1'b0;
        end
    end

    assign match_now = eff.assigned && (eff.device == dev_reg) && (eff.block == blk_reg);
    assign free_now  = (eff.count == '0);

    always_comb
    begin
        state_next      = state_reg;
        rd_addr_next    = rd_addr_reg;
        cmd_next        = cmd_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        now_next        = now_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_lu_next    = free_lu_reg;
        res_next        = res_reg;
        written_next    = written_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_addr_reg;
        wr_data         = eff;
        cnt_new         = '0;
        lu_new          = eff.last_use;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = req.command;
                    dev_next        = req.device;
                    blk_next        = req.block_number;
                    now_next        = req.now;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    if (req.command == CMD_GET)
                    begin
                        rd_addr_next = '0;
                        state_next   = S_SCAN;
                    end
                    else if (slot_in_range)
                    begin
                        rd_addr_next = slot_wide[IDX_W-1:0];
                        state_next   = S_WRITE;
                    end
                    else
                    begin
                        // slot beyond the table: ignore, report the slot
                        res_next.slot_out    = req.slot;
                        res_next.hit         = 1'b0;
                        res_next.needs_read  = 1'b0;
                        res_next.status      = ST_OK;
                        res_next.count_after = '0;
                        state_next           = S_EMIT;
                    end
                end
            end

            S_SCAN:
            begin
                // keep the first tag match and the oldest free entry, lowest slot on ties
                if (match_now && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_addr_reg;
                    hit_ent_next   = eff;
                end
                if (free_now && (!free_found_reg || (eff.last_use < free_lu_reg)))
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_addr_reg;
                    free_lu_next    = eff.last_use;
                end
                rd_addr_next = rd_addr_reg + IDX_W'(1);
                if (rd_addr_reg == LAST_IDX)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                res_next.slot_out   = idx_to_slot(rd_addr_reg);
                res_next.hit        = 1'b0;
                res_next.needs_read = 1'b0;
                res_next.status     = ST_OK;
                case (cmd_reg)
                    CMD_GET:
                    begin
                        if (hit_found_reg)
                        begin
                            cnt_new              = sat_inc(hit_ent_reg.count);
                            wr_en                = 1'b1;
                            wr_addr              = hit_idx_reg;
                            wr_data              = hit_ent_reg;
                            wr_data.count        = cnt_new;
                            wr_data.valid        = 1'b1;
                            res_next.slot_out    = idx_to_slot(hit_idx_reg);
                            res_next.hit         = 1'b1;
                            res_next.needs_read  = !hit_ent_reg.valid;
                            res_next.count_after = cnt_new;
                        end
                        else if (free_found_reg)
                        begin
                            // claim and retag the least recently used free entry
                            wr_en                = 1'b1;
                            wr_addr              = free_idx_reg;
                            wr_data.device       = dev_reg;
                            wr_data.block        = blk_reg;
                            wr_data.assigned     = 1'b1;
                            wr_data.count        = CNT_W'(1);
                            wr_data.last_use     = free_lu_reg;
                            wr_data.valid        = 1'b1;
                            res_next.slot_out    = idx_to_slot(free_idx_reg);
                            res_next.needs_read  = 1'b1;
                            res_next.count_after = CNT_W'(1);
                        end
                        else
                        begin
                            res_next.slot_out    = '0;
                            res_next.status      = ST_NOFREE;
                            res_next.count_after = '0;
                        end
                    end
                    CMD_PIN:
                    begin
                        cnt_new              = sat_inc(eff.count);
                        wr_en                = 1'b1;
                        wr_data.count        = cnt_new;
                        res_next.count_after = cnt_new;
                    end
                    default:
                    begin
                        // release or unpin
                        if (eff.count == '0)
                        begin
                            res_next.status      = ST_UNDER;
                            res_next.count_after = '0;
                        end
                        else
                        begin
                            cnt_new = eff.count - CNT_W'(1);
                            if ((cmd_reg == CMD_RELEASE) && (cnt_new == '0))
                            begin
                                lu_new = now_reg;
                            end
                            wr_en                = 1'b1;
                            wr_data.count        = cnt_new;
                            wr_data.last_use     = lu_new;
                            res_next.count_after = cnt_new;
                        end
                    end
                endcase
                if (wr_en)
                begin
                    written_next[wr_addr] = 1'b1;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: load a finished result, drop it once taken
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_addr_reg    <= '0;
            cmd_reg        <= CMD_GET;
            dev_reg        <= '0;
            blk_reg        <= '0;
            now_reg        <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_ent_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            free_lu_reg    <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            written_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_addr_reg    <= rd_addr_next;
            cmd_reg        <= cmd_next;
            dev_reg        <= dev_next;
            blk_reg        <= blk_next;
            now_reg        <= now_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            hit_ent_reg    <= hit_ent_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            free_lu_reg    <= free_lu_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            written_reg    <= written_next;
        end
    end

    // Entry table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg    <= mem[rd_addr_next];
        rd_written_reg <= written_reg[rd_addr_next];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.slot_out    = out_reg.slot_out;
    assign rsp.hit         = out_reg.hit;
    assign rsp.needs_read  = out_reg.needs_read;
    assign rsp.status      = out_reg.status;
    assign rsp.count_after = out_reg.count_after;

    // A full table reports nothing but the error
    a_nofree_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_NOFREE))
            |-> (!rsp.hit && !rsp.needs_read && (rsp.count_after == '0)))
        else $error("no-free result carries entry data");

    // A hit always leaves a live reference
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> ((rsp.status == ST_OK) && (rsp.count_after != '0)))
        else $error("hit result without a reference");

    // A written entry is never read back as its reset value
    a_written_mark: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> written_reg[$past(wr_addr)])
        else $error("entry write not recorded");

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready && (state_reg == S_EMIT)) |=> (state_reg == S_EMIT))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
